[hw/rtl/md5_message_digest_defines.svh]
// Assertion macros for the MD5 digest block
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH

// implication checked every clock edge, muted in reset
`define MD5_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MD5_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/md5_pkg.sv]
// Package: constants, tables and types for the MD5 digest block
package md5_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ZERO,
		ST_LEN,
		ST_PREP,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic        wr_en;
		logic [3:0]  wr_addr;
		logic [31:0] wr_data;
		logic [3:0]  rd_addr;
	} mem_req_t;

	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	function automatic logic [31:0] round_const(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
			4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
		endcase
		return s;
	endfunction

	// message word index used by round i
	function automatic logic [3:0] msg_index(input logic [5:0] i);
		logic [3:0] g;
		case (i[5:4])
			2'd0:    g = i[3:0];
			2'd1:    g = 4'(5 * i[3:0] + 1);
			2'd2:    g = 4'(3 * i[3:0] + 5);
			default: g = 4'(7 * i[3:0]);
		endcase
		return g;
	endfunction

	function automatic logic [31:0] swap_bytes(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

[hw/rtl/md5_stream_if.sv]
// Valid/ready stream interface
interface md5_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/md5_message_digest.sv]
// MD5 digest top level: byte packing, padding, round sequencer and digest output
//   channel  dir  payload                                  transfer when
//   in       in   data_byte, byte_valid, end_of_message    in.valid & in.ready
//   out      out  digest_word, word_number, last_word      out.valid & out.ready
// Bytes are accepted while idle; a byte that fills a block starts a compression.
// Message end: zero fill and length write, one or two compressions
// (one round per cycle reading the block RAM), then four output transfers.
// Input is held off during padding, compression and digest output; output stalls hold the word.
// arst_n returns the chaining words and counters to the initial values; no clearing pass.
module md5_message_digest (
	input logic clk,
	input logic arst_n,
	md5_stream_if.sink   in,
	md5_stream_if.source out
);
	`include "md5_message_digest_defines.svh"

	md5_pkg::state_t st_q, st_d;
	logic [31:0] ch_q [4];
	logic [31:0] wk_q [4];
	logic [63:0] cnt_q;
	logic [5:0]  rnd_q;
	logic [5:0]  pos_q;
	logic [31:0] acc_q;
	logic        fin_q;
	logic        two_q;
	logic        pad_q;
	logic [1:0]  wn_q;
	logic [31:0] rd_data;
	logic [31:0] b_next;
	logic [63:0] bits;
	md5_pkg::mem_req_t req;
	logic        take;
	logic [31:0] word_new;
	logic [31:0] pad_hi;
	logic [7:0]  bval;
	logic        two_new;
	logic        fold_done;

	assign in.ready = (st_q == md5_pkg::ST_IDLE);
	assign take = in.valid && in.ready;
	assign bits = {cnt_q[60:0], 3'b000};
	assign bval = in.payload.byte_valid ? in.payload.data_byte : md5_pkg::PAD_BYTE;
	// pad marker lands at byte 56 or later: a further block is needed
	assign two_new = (cnt_q[5:0] >= 6'd56)
		|| (cnt_q[5:0] == 6'd55 && in.payload.byte_valid);

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    word_new = {24'd0, bval};
			2'd1:    word_new = {16'd0, bval, acc_q[7:0]};
			2'd2:    word_new = {8'd0, bval, acc_q[15:0]};
			default: word_new = {bval, acc_q[23:0]};
		endcase
	end

	// pad marker after a final byte in the same word
	always_comb begin
		pad_hi = 32'd0;
		if (in.payload.byte_valid && in.payload.end_of_message) begin
			case (cnt_q[1:0])
				2'd0:    pad_hi = {16'd0, md5_pkg::PAD_BYTE, 8'd0};
				2'd1:    pad_hi = {8'd0, md5_pkg::PAD_BYTE, 16'd0};
				2'd2:    pad_hi = {md5_pkg::PAD_BYTE, 24'd0};
				default: pad_hi = 32'd0;
			endcase
		end
	end

	md5_block_ram u_ram (.clk(clk), .req(req), .rd_data(rd_data));

	md5_round u_round (
		.round(rnd_q), .a(wk_q[0]), .b(wk_q[1]), .c(wk_q[2]), .d(wk_q[3]),
		.m(rd_data), .b_next(b_next)
	);

	assign fold_done = fin_q && !two_q;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			md5_pkg::ST_IDLE: begin
				if (take) begin
					if (in.payload.end_of_message) begin
						if (two_new) begin
							st_d = (cnt_q[5:2] == 4'd15) ? md5_pkg::ST_PREP
								: md5_pkg::ST_ZERO;
						end else begin
							st_d = (cnt_q[5:2] == 4'd13) ? md5_pkg::ST_LEN
								: md5_pkg::ST_ZERO;
						end
					end else if (in.payload.byte_valid && cnt_q[5:0] == 6'd63) begin
						st_d = md5_pkg::ST_PREP;
					end
				end
			end
			md5_pkg::ST_ZERO: begin
				if (pos_q == 6'd15 || (!two_q && pos_q == 6'd13)) begin
					st_d = two_q ? md5_pkg::ST_PREP : md5_pkg::ST_LEN;
				end
			end
			md5_pkg::ST_LEN: begin
				if (pos_q[0]) st_d = md5_pkg::ST_PREP;
			end
			md5_pkg::ST_PREP:  st_d = md5_pkg::ST_ROUND;
			md5_pkg::ST_ROUND: if (rnd_q == 6'd63) st_d = md5_pkg::ST_FOLD;
			md5_pkg::ST_FOLD: begin
				if (!fin_q) st_d = md5_pkg::ST_IDLE;
				else if (two_q) st_d = md5_pkg::ST_ZERO;
				else st_d = md5_pkg::ST_OUT;
			end
			md5_pkg::ST_OUT: if (out.ready && wn_q == 2'd3) st_d = md5_pkg::ST_IDLE;
			default: st_d = md5_pkg::ST_IDLE;
		endcase
	end

	// RAM requests
	always_comb begin
		req.wr_en = 1'b0;
		req.wr_addr = pos_q[3:0];
		req.wr_data = 32'd0;
		req.rd_addr = md5_pkg::msg_index(rnd_q);
		case (st_q)
			md5_pkg::ST_IDLE: begin
				req.wr_en = take && (in.payload.byte_valid || in.payload.end_of_message);
				req.wr_addr = cnt_q[5:2];
				req.wr_data = word_new | pad_hi;
			end
			md5_pkg::ST_ZERO: begin
				req.wr_en = 1'b1;
				req.wr_data = pad_q ? {24'd0, md5_pkg::PAD_BYTE} : 32'd0;
			end
			md5_pkg::ST_LEN: begin
				req.wr_en = 1'b1;
				req.wr_data = pos_q[0] ? bits[63:32] : bits[31:0];
			end
			md5_pkg::ST_PREP:  req.rd_addr = md5_pkg::msg_index(6'd0);
			md5_pkg::ST_ROUND: req.rd_addr = md5_pkg::msg_index(rnd_q + 6'd1);
			default: ;
		endcase
	end

	// outputs
	always_comb begin
		out.valid = (st_q == md5_pkg::ST_OUT);
		out.payload.digest_word = md5_pkg::swap_bytes(ch_q[wn_q]);
		out.payload.word_number = wn_q;
		out.payload.last_word = (wn_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= md5_pkg::ST_IDLE;
			ch_q <= '{md5_pkg::INIT_A, md5_pkg::INIT_B, md5_pkg::INIT_C, md5_pkg::INIT_D};
			wk_q <= '{default: 32'd0};
			cnt_q <= 64'd0;
			rnd_q <= 6'd0;
			pos_q <= 6'd0;
			acc_q <= 32'd0;
			fin_q <= 1'b0;
			two_q <= 1'b0;
			pad_q <= 1'b0;
			wn_q <= 2'd0;
		end else begin
			st_q <= st_d;
			case (st_q)
				md5_pkg::ST_IDLE: begin
					if (take) begin
						if (in.payload.byte_valid || in.payload.end_of_message) begin
							acc_q <= word_new;
						end
						if (in.payload.byte_valid) cnt_q <= cnt_q + 64'd1;
						if (in.payload.end_of_message) begin
							fin_q <= 1'b1;
							two_q <= two_new;
							pad_q <= in.payload.byte_valid && (cnt_q[1:0] == 2'd3);
							pos_q <= {2'b00, cnt_q[5:2]} + 6'd1;
						end
					end
				end
				md5_pkg::ST_ZERO: begin
					pad_q <= 1'b0;
					if (st_d == md5_pkg::ST_LEN) pos_q <= 6'd14;
					else pos_q <= pos_q + 6'd1;
				end
				md5_pkg::ST_LEN: pos_q <= pos_q + 6'd1;
				md5_pkg::ST_PREP: begin
					wk_q <= ch_q;
					rnd_q <= 6'd0;
				end
				md5_pkg::ST_ROUND: begin
					wk_q <= '{wk_q[3], b_next, wk_q[1], wk_q[2]};
					rnd_q <= rnd_q + 6'd1;
				end
				md5_pkg::ST_FOLD: begin
					for (int i = 0; i < 4; i++) ch_q[i] <= ch_q[i] + wk_q[i];
					if (two_q) begin
						two_q <= 1'b0;
						pos_q <= 6'd0;
					end
				end
				md5_pkg::ST_OUT: begin
					if (out.ready) begin
						wn_q <= wn_q + 2'd1;
						if (wn_q == 2'd3) begin
							ch_q <= '{md5_pkg::INIT_A, md5_pkg::INIT_B,
								md5_pkg::INIT_C, md5_pkg::INIT_D};
							cnt_q <= 64'd0;
							fin_q <= 1'b0;
							acc_q <= 32'd0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	`MD5_ASSERT_IMP(a_ready_idle, clk, arst_n, in.ready, !out.valid, "input open during digest")
	`MD5_ASSERT_IMP(a_out_final, clk, arst_n, out.valid, fold_done, "digest without final block")
	`MD5_ASSERT_NXT(a_round_step, clk, arst_n,
		st_q == md5_pkg::ST_ROUND && rnd_q != 6'd63, rnd_q == $past(rnd_q) + 6'd1,
		"round counter skipped")
endmodule

[hw/rtl/md5_block_ram.sv]
// 16 x 32 message block store, one write and one registered read port
module md5_block_ram (
	input  logic        clk,
	input  md5_pkg::mem_req_t req,
	output logic [31:0] rd_data
);
	logic [31:0] mem [16];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		rd_data <= mem[req.rd_addr];
	end
endmodule

[hw/rtl/md5_round.sv]
// One MD5 round step on the working words
module md5_round (
	input  logic [5:0]  round,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  logic [31:0] d,
	input  logic [31:0] m,
	output logic [31:0] b_next
);
	logic [31:0] f;
	logic [31:0] sum;
	logic [4:0]  s;

	always_comb begin
		case (round[5:4])
			2'd0:    f = (b & c) | (~b & d);
			2'd1:    f = (d & b) | (~d & c);
			2'd2:    f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		sum = f + a + md5_pkg::round_const(round) + m;
		s = md5_pkg::rot_amount(round);
		b_next = b + ((sum << s) | (sum >> (6'd32 - {1'b0, s})));
	end
endmodule

[tb/sv/tb.sv]
// Testbench for md5_message_digest: byte stream stimulus, digest prediction and checking
module tb;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_number;
		logic        last_word;
	} digest_item_t;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 300;

	localparam logic [31:0] SINE_TABLE [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};
	localparam int SHIFT_TABLE [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
		4, 11, 16, 23, 6, 10, 15, 21};
	localparam logic [31:0] CHAIN_START [4] = '{32'h67452301, 32'hefcdab89,
		32'h98badcfe, 32'h10325476};

	logic clk;
	logic arst_n;

	md5_stream_if #(.payload_t(byte_item_t))   byte_chan ();
	md5_stream_if #(.payload_t(digest_item_t)) digest_chan ();

	md5_message_digest u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (byte_chan),
		.out    (digest_chan)
	);

	logic [31:0]  chain [4];
	logic [31:0]  block_words [16];
	logic [63:0]  msg_bytes;
	digest_item_t pending_digests [$];
	int           errors;
	int           cycles;
	int           items_sent;
	int           burst_left;
	int           hold_requests;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
		return (x << s) | (x >> (32 - s));
	endfunction

	task automatic compress_block();
		logic [31:0] a, b, c, d, f;
		int g;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		for (int i = 0; i < 64; i++) begin
			case (i >> 4)
				0: begin
					f = (b & c) | (~b & d);
					g = i;
				end
				1: begin
					f = (d & b) | (~d & c);
					g = (5 * i + 1) & 15;
				end
				2: begin
					f = b ^ c ^ d;
					g = (3 * i + 5) & 15;
				end
				default: begin
					f = c ^ (b | ~d);
					g = (7 * i) & 15;
				end
			endcase
			f = rotl(f + a + SINE_TABLE[i] + block_words[g], SHIFT_TABLE[((i >> 4) << 2) | (i & 3)]);
			a = d;
			d = c;
			c = b;
			b = b + f;
		end
		chain[0] += a;
		chain[1] += b;
		chain[2] += c;
		chain[3] += d;
	endtask

	task automatic put_byte(input int pos, input logic [7:0] v);
		if ((pos & 3) == 0)
			block_words[pos >> 2] = '0;
		block_words[pos >> 2][(pos & 3) * 8 +: 8] = v;
	endtask

	task automatic clear_digest_state();
		chain = CHAIN_START;
		foreach (block_words[i])
			block_words[i] = '0;
		msg_bytes = '0;
	endtask

	task automatic absorb_item(input byte_item_t it);
		int pos;
		logic [63:0] bit_len;
		digest_item_t d;
		if (it.byte_valid) begin
			pos = int'(msg_bytes[5:0]);
			put_byte(pos, it.data_byte);
			msg_bytes++;
			if (pos == 63)
				compress_block();
		end
		if (!it.end_of_message)
			return;
		pos = int'(msg_bytes[5:0]);
		put_byte(pos, 8'h80);
		for (int i = pos + 1; i < 64; i++)
			put_byte(i, 8'h00);
		if (pos >= 56) begin
			compress_block();
			foreach (block_words[i])
				block_words[i] = '0;
		end
		bit_len = msg_bytes << 3;
		block_words[14] = bit_len[31:0];
		block_words[15] = bit_len[63:32];
		compress_block();
		for (int i = 0; i < 4; i++) begin
			d.digest_word = {chain[i][7:0], chain[i][15:8], chain[i][23:16], chain[i][31:24]};
			d.word_number = 2'(i);
			d.last_word = (i == 3);
			pending_digests.insert(pending_digests.size(), d);
		end
		clear_digest_state();
	endtask

	// sender: bursts of back-to-back transfers separated by random gaps
	task automatic send_item(input logic [7:0] data, input logic v, input logic eom);
		byte_item_t it;
		it.data_byte = data;
		it.byte_valid = v;
		it.end_of_message = eom;
		byte_chan.valid <= 1'b1;
		byte_chan.payload <= it;
		do
			@(posedge clk);
		while (!byte_chan.ready);
		absorb_item(it);
		if (v || eom)
			items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			if ($urandom_range(0, 2) != 0) begin
				byte_chan.valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	task automatic stop_sending();
		byte_chan.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_digests.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_message(input int len, input bit separate_end);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, !separate_end && (i == len - 1));
		end
		if (separate_end || len == 0)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic test_directed();
		send_item(8'h5a, 1'b0, 1'b0);
		send_item(8'ha5, 1'b0, 1'b1);
		send_item(8'h00, 1'b1, 1'b1);
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h61, 1'b1, 1'b0);
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b1);
		send_item(8'h00, 1'b0, 1'b1);
		stop_sending();
	endtask

	task automatic test_pressure();
		wait_drained();
		hold_requests++;
		send_message(20, 1'b0);
		send_message(12, 1'b1);
		send_message(5, 1'b0);
		stop_sending();
		wait_drained();
	endtask

	task automatic test_random();
		int len;
		while (items_sent < 230) begin
			case ($urandom_range(0, 3))
				0: len = 55 + $urandom_range(0, 10);
				1: len = $urandom_range(0, 3);
				default: len = $urandom_range(0, 40);
			endcase
			send_message(len, 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 5) == 0) begin
				stop_sending();
				wait_drained();
			end
		end
		stop_sending();
	endtask

	// receiver: stall pattern redrawn periodically from the cycle counter; long hold-off on request
	always @(posedge clk) begin
		static int hold_left = 0;
		static int hold_seen = 0;
		static int stall_mode = 0;
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (cycles % 64 == 0)
			stall_mode = $urandom_range(0, 2);
		if (hold_left > 0) begin
			hold_left--;
			digest_chan.ready <= 1'b0;
		end else if (stall_mode == 0) begin
			digest_chan.ready <= 1'b1;
		end else begin
			digest_chan.ready <= ($urandom_range(0, stall_mode) == 0);
		end
	end

	always @(posedge clk) begin
		digest_item_t got, want;
		if (arst_n && digest_chan.valid && digest_chan.ready) begin
			got = digest_chan.payload;
			if (pending_digests.size() == 0) begin
				$error("unexpected digest transfer: word %h", got.digest_word);
				errors++;
			end else begin
				want = pending_digests.pop_front();
				if (got.digest_word !== want.digest_word) begin
					$error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
					errors++;
				end
				if (got.word_number !== want.word_number) begin
					$error("word_number: expected %0d, got %0d", want.word_number, got.word_number);
					errors++;
				end
				if (got.last_word !== want.last_word) begin
					$error("last_word: expected %0d, got %0d", want.last_word, got.last_word);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		items_sent = 0;
		burst_left = 0;
		hold_requests = 0;
		clear_digest_state();
		arst_n = 1'b0;
		byte_chan.valid = 1'b0;
		byte_chan.payload = '0;
		digest_chan.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pressure();
		test_random();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending_digests.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
